[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL; clock clk, reset arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed: always");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next cycle");

`endif

[hw/rtl/sfb_pkg.sv]
package sfb_pkg;

	localparam int DATA_BYTES_DEF = 32;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic [7:0]  HDR_START  = 8'hA8;
	localparam logic [7:0]  HDR_STATUS = 8'h03;
	localparam logic [7:0]  HDR_CHANS  = 8'h12;
	localparam logic [7:0]  ZERO_BYTE  = 8'h00;
	localparam logic [15:0] CRC_POLY   = 16'h1021;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] func;
		logic       first;
		logic       last;
	} sfb_item_t;

	typedef enum logic [3:0] {
		ST_H0,
		ST_H1,
		ST_H2,
		ST_DATA,
		ST_FUNC,
		ST_Z0,
		ST_Z1,
		ST_Z2,
		ST_CRCH,
		ST_CRCL
	} sfb_step_t;

	// CRC-16, polynomial 0x1021, MSB first, one byte folded in.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[hw/rtl/sfb_front.sv]
module sfb_front import sfb_pkg::*; #(
	parameter int DATA_BYTES = DATA_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic [7:0] function_code,
	input  logic       q_full,
	output logic       q_push,
	output sfb_item_t  q_item
);

	localparam int POS_W = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(DATA_BYTES - 1);

	logic [POS_W-1:0] pos_q;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_item.data  = data_byte;
		q_item.func  = function_code;
		q_item.first = (pos_q == '0);
		q_item.last  = (pos_q == POS_LAST);
	end

	// Advance the frame position on every accepted beat, wrap after the last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (q_push) begin
			if (pos_q == POS_LAST) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

[hw/rtl/sfb_queue.sv]
`include "assert_macros.svh"

module sfb_queue import sfb_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  sfb_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      pop_valid,
	output sfb_item_t pop_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	sfb_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_FULL);
	assign pop_valid = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_IMPLIES(a_no_push_full, push, !full)
	`ASSERT_IMPLIES(a_no_pop_empty, pop, pop_valid)
	`ASSERT_ALWAYS(a_count_bound, count_q <= CNT_FULL)

endmodule

[hw/rtl/sfb_back.sv]
`include "assert_macros.svh"

module sfb_back import sfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  sfb_item_t  q_item,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] frame_byte,
	output logic       run_last,
	output logic       frame_last
);

	sfb_step_t   step_q;
	sfb_step_t   step_d;
	sfb_step_t   step_nx;
	logic        active_q;
	logic        active_d;
	sfb_item_t   item_q;
	logic [15:0] crc_q;
	logic [15:0] crc_base;
	logic        crc_upd;
	logic [7:0]  byte_c;
	logic        run_last_c;
	logic        frame_last_c;
	logic        advance;
	logic        item_done;

	logic       out_valid_q;
	logic [7:0] frame_byte_q;
	logic       run_last_q;
	logic       frame_last_q;

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign run_last   = run_last_q;
	assign frame_last = frame_last_q;

	always_comb begin
		byte_c       = ZERO_BYTE;
		run_last_c   = 1'b0;
		frame_last_c = 1'b0;
		crc_upd      = 1'b1;
		crc_base     = crc_q;
		step_nx      = ST_DATA;
		case (step_q)
			ST_H0: begin
				byte_c   = HDR_START;
				crc_base = '0;
				step_nx  = ST_H1;
			end
			ST_H1: begin
				byte_c  = HDR_STATUS;
				step_nx = ST_H2;
			end
			ST_H2: begin
				byte_c  = HDR_CHANS;
				step_nx = ST_DATA;
			end
			ST_DATA: begin
				byte_c = item_q.data;
				if (item_q.last) begin
					step_nx = ST_FUNC;
				end else begin
					run_last_c = 1'b1;
				end
			end
			ST_FUNC: begin
				byte_c  = item_q.func;
				step_nx = ST_Z0;
			end
			ST_Z0: step_nx = ST_Z1;
			ST_Z1: step_nx = ST_Z2;
			ST_Z2: step_nx = ST_CRCH;
			ST_CRCH: begin
				byte_c  = crc_q[15:8];
				crc_upd = 1'b0;
				step_nx = ST_CRCL;
			end
			ST_CRCL: begin
				byte_c       = crc_q[7:0];
				crc_upd      = 1'b0;
				run_last_c   = 1'b1;
				frame_last_c = 1'b1;
			end
			default: begin
				crc_upd = 1'b0;
			end
		endcase

		advance   = active_q && (!out_valid_q || out_ready);
		item_done = advance && run_last_c;
		// Take the next item as the current one retires, so beats run gap-free.
		q_pop     = q_valid && (!active_q || item_done);

		step_d   = step_q;
		active_d = active_q;
		if (q_pop) begin
			step_d   = q_item.first ? ST_H0 : ST_DATA;
			active_d = 1'b1;
		end else if (item_done) begin
			active_d = 1'b0;
		end else if (advance) begin
			step_d = step_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_DATA;
			active_q    <= 1'b0;
			crc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			step_q   <= step_d;
			active_q <= active_d;
			if (advance && crc_upd) begin
				crc_q <= crc_byte(crc_base, byte_c);
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (advance) begin
			frame_byte_q <= byte_c;
			run_last_q   <= run_last_c;
			frame_last_q <= frame_last_c;
		end
	end

	`ASSERT_IMPLIES(a_frame_end_ends_run, out_valid_q && frame_last_q, run_last_q)
	`ASSERT_NEXT(a_crc_high_then_low, advance && step_q == ST_CRCH, step_q == ST_CRCL)
	`ASSERT_IMPLIES(a_pop_only_when_free, q_pop, !active_q || item_done)

endmodule

[hw/rtl/sumd_frame_builder_unit.sv]
// Channel | Handshake           | Payload
// in      | in_valid, in_ready  | data_byte, function_code
// out     | out_valid, out_ready| frame_byte, run_last, frame_last
//
// One frame byte leaves per cycle unless the output stalls or the queue runs
// dry; an item yields 4 bytes at frame start, 7 at frame end and 1 otherwise,
// so a frame has DATA_BYTES + 9 bytes. The back sequencer's single byte per
// cycle sets that rate; the front takes a beat per cycle while the four-entry
// queue has room. Beats pass the queue and item_q before the output register.
// Reset (arst_n low) empties the queue and restarts at the frame's first byte.
// A stalled output holds its beat; the front keeps filling the queue meanwhile.
module sumd_frame_builder_unit import sfb_pkg::*; #(
	parameter int DATA_BYTES = DATA_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic [7:0] function_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] frame_byte,
	output logic       run_last,
	output logic       frame_last
);

	logic      q_full;
	logic      q_push;
	sfb_item_t q_push_item;
	logic      q_pop;
	logic      q_valid;
	sfb_item_t q_pop_item;

	sfb_front #(
		.DATA_BYTES(DATA_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.function_code(function_code),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_push_item)
	);

	sfb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(q_push_item),
		.full     (q_full),
		.pop      (q_pop),
		.pop_valid(q_valid),
		.pop_item (q_pop_item)
	);

	sfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_pop_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.frame_byte(frame_byte),
		.run_last  (run_last),
		.frame_last(frame_last)
	);

endmodule
